// ----- hw/rtl/ttps_pkg.sv -----
`timescale 1ns / 1ps
package ttps_pkg;

   localparam int KEY_W                 = 64;
   localparam int MOVE_W                = 32;
   localparam int SCORE_W               = 16;
   localparam int PLY_W                 = 7;
   localparam int DEPTH_W               = 6;
   localparam int FLAGS_W               = 2;
   localparam int THR_W                 = 15;
   localparam int COUNT_W               = 32;

   localparam int TABLE_ENTRIES_DEFAULT = 1024;
   localparam logic [THR_W-1:0] MATE_THRESHOLD_RESET = 15'd29936;

   localparam int DIV_BITS              = 4;
   localparam int DIV_CYCLES            = KEY_W / DIV_BITS;
   localparam int QUEUE_DEPTH           = 2;

   typedef enum logic [1:0] {
      OP_PROBE = 2'd0,
      OP_STORE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_SWEEP,
      B_IDLE,
      B_LOOK
   } back_state_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_W-1:0]     key;
      logic [PLY_W-1:0]     ply;
      logic [MOVE_W-1:0]    move;
      logic [SCORE_W-1:0]   score;
      logic [SCORE_W-1:0]   eval;
      logic [DEPTH_W-1:0]   depth;
      logic [FLAGS_W-1:0]   flags;
   } cmd_type;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [MOVE_W-1:0]    move;
      logic [SCORE_W-1:0]   score;
      logic [SCORE_W-1:0]   eval;
      logic [DEPTH_W-1:0]   depth;
      logic [FLAGS_W-1:0]   flags;
   } entry_type;

   function automatic logic [SCORE_W-1:0] sat16(input logic signed [17:0] v);
      logic [SCORE_W-1:0] r;
      if (v > 18'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [SCORE_W-1:0] mate_adjust(
      input logic [SCORE_W-1:0] score,
      input logic [PLY_W-1:0]   ply,
      input logic [THR_W-1:0]   thr,
      input logic               outward
   );
      logic signed [17:0] s;
      logic signed [17:0] t;
      logic signed [17:0] p;
      logic signed [17:0] r;
      s = {{2{score[15]}}, score};
      t = {3'b000, thr};
      p = {11'd0, ply};
      if (s > t) begin
         r = outward ? s + p : s - p;
      end else if (s < -t) begin
         r = outward ? s - p : s + p;
      end else begin
         r = s;
      end
      return sat16(r);
   endfunction

endpackage

// ----- hw/rtl/ttps_front.sv -----
`timescale 1ns / 1ps
module ttps_front #(
   parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [ttps_pkg::KEY_W-1:0]          req_pos_key,
   input  logic [ttps_pkg::PLY_W-1:0]          req_ply,
   input  logic [ttps_pkg::MOVE_W-1:0]         req_move,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_score,
   input  logic signed [ttps_pkg::SCORE_W-1:0] req_eval,
   input  logic [ttps_pkg::DEPTH_W-1:0]        req_depth,
   input  logic [ttps_pkg::FLAGS_W-1:0]        req_flags,
   input  logic [ttps_pkg::THR_W-1:0]          mate_threshold,
   input  logic                                table_busy,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [IDX_W-1:0]                    q_slot,
   output ttps_pkg::cmd_type                   q_cmd
);

   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
   localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(ttps_pkg::DIV_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ttps_pkg::DIV_CYCLES - 1);

   ttps_pkg::front_state_type state_ff, state_in;
   ttps_pkg::cmd_type         cmd_ff, req_cmd;
   logic [IDX_W:0]            rem_ff, rem_in;
   logic [ttps_pkg::KEY_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      accept;
   logic                      needs_slot;

   assign accept     = req_valid && !req_stall;
   assign needs_slot = (req_cmd.op == ttps_pkg::OP_PROBE) || (req_cmd.op == ttps_pkg::OP_STORE);

   always_comb begin
      req_cmd.op    = ttps_pkg::op_type'(req_type);
      req_cmd.key   = req_pos_key;
      req_cmd.ply   = req_ply;
      req_cmd.move  = req_move;
      req_cmd.score = (req_cmd.op == ttps_pkg::OP_STORE) ?
                      ttps_pkg::mate_adjust(req_score, req_ply, mate_threshold, 1'b1) :
                      req_score;
      req_cmd.eval  = req_eval;
      req_cmd.depth = req_depth;
      req_cmd.flags = req_flags;
   end

   always_comb begin
      logic [IDX_W:0]             r;
      logic [ttps_pkg::KEY_W-1:0] sh;
      r  = rem_ff;
      sh = shift_ff;
      for (int i = 0; i < ttps_pkg::DIV_BITS; i++) begin
         r  = {r[IDX_W-1:0], sh[ttps_pkg::KEY_W-1]};
         sh = {sh[ttps_pkg::KEY_W-2:0], 1'b0};
         if (r >= MODULUS) begin
            r = r - MODULUS;
         end
      end
      rem_in   = r;
      shift_in = sh;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttps_pkg::F_IDLE: begin
            if (accept) begin
               state_in = (needs_slot && !IS_POW2) ? ttps_pkg::F_DIV : ttps_pkg::F_PUSH;
            end
         end
         ttps_pkg::F_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ttps_pkg::F_PUSH;
            end
         end
         ttps_pkg::F_PUSH: begin
            if (!q_full) begin
               state_in = ttps_pkg::F_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ttps_pkg::F_IDLE) || table_busy;
      q_push    = (state_ff == ttps_pkg::F_PUSH) && !q_full;
      q_slot    = rem_ff[IDX_W-1:0];
      q_cmd     = cmd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttps_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ttps_pkg::F_IDLE && accept) begin
         cmd_ff   <= req_cmd;
         shift_ff <= req_pos_key;
         cnt_ff   <= '0;
         rem_ff   <= IS_POW2 ? {1'b0, req_pos_key[IDX_W-1:0]} : '0;
      end else if (state_ff == ttps_pkg::F_DIV) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
         cnt_ff   <= cnt_ff + CNT_W'(1);
      end
   end

endmodule

// ----- hw/rtl/ttps_queue.sv -----
`timescale 1ns / 1ps
module ttps_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = $clog2(ttps_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(ttps_pkg::QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [ttps_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = count_ff == CNT_W'(ttps_pkg::QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/ttps_back.sv -----
`timescale 1ns / 1ps
module ttps_back #(
   parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int IDX_W         = $clog2(TABLE_ENTRIES)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 q_empty,
   output logic                                 q_pop,
   input  logic [IDX_W-1:0]                     q_slot,
   input  ttps_pkg::cmd_type                    q_cmd,
   input  logic [ttps_pkg::THR_W-1:0]           mate_threshold,
   output logic                                 table_busy,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [ttps_pkg::MOVE_W-1:0]          rsp_found_move,
   output logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_score,
   output logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_eval,
   output logic [ttps_pkg::DEPTH_W-1:0]         rsp_found_depth,
   output logic [ttps_pkg::FLAGS_W-1:0]         rsp_found_flags,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_hits_total,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_new_writes_total,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_overwrites_total
);

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

   ttps_pkg::back_state_type state_ff, state_in;
   ttps_pkg::entry_type      mem [TABLE_ENTRIES];
   ttps_pkg::entry_type      rd_ff;
   ttps_pkg::entry_type      wr_data;
   ttps_pkg::cmd_type        cmd_ff;
   logic [IDX_W-1:0]         slot_ff;
   logic [IDX_W-1:0]         sweep_ptr_ff;
   logic [IDX_W-1:0]         wr_addr;
   logic                     wr_en;
   logic                     sweep_rsp_ff;
   logic                     sweep_last;
   logic                     out_free;
   logic                     look_hit;
   logic                     load_look, load_nop, load_clear;
   logic [ttps_pkg::SCORE_W-1:0] look_score;

   logic                              rsp_valid_ff;
   logic                              hit_ff;
   logic [ttps_pkg::MOVE_W-1:0]       move_ff;
   logic [ttps_pkg::SCORE_W-1:0]      score_ff;
   logic [ttps_pkg::SCORE_W-1:0]      eval_ff;
   logic [ttps_pkg::DEPTH_W-1:0]      depth_ff;
   logic [ttps_pkg::FLAGS_W-1:0]      flags_ff;
   logic [ttps_pkg::COUNT_W-1:0]      hits_ff, new_writes_ff, overwrites_ff;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_last = sweep_ptr_ff == LAST_SLOT;
   assign look_hit   = (cmd_ff.op == ttps_pkg::OP_PROBE) && (rd_ff.key == cmd_ff.key);
   assign look_score = ttps_pkg::mate_adjust(rd_ff.score, cmd_ff.ply, mate_threshold, 1'b0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttps_pkg::B_SWEEP: begin
            if (sweep_last) begin
               state_in = ttps_pkg::B_IDLE;
            end
         end
         ttps_pkg::B_IDLE: begin
            if (q_pop) begin
               unique case (q_cmd.op)
                  ttps_pkg::OP_PROBE,
                  ttps_pkg::OP_STORE: state_in = ttps_pkg::B_LOOK;
                  ttps_pkg::OP_CLEAR: state_in = ttps_pkg::B_SWEEP;
                  ttps_pkg::OP_NONE:  state_in = ttps_pkg::B_IDLE;
               endcase
            end
         end
         ttps_pkg::B_LOOK: begin
            state_in = ttps_pkg::B_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop      = (state_ff == ttps_pkg::B_IDLE) && !q_empty && out_free;
      table_busy = state_ff == ttps_pkg::B_SWEEP;
      load_look  = state_ff == ttps_pkg::B_LOOK;
      load_nop   = q_pop && (q_cmd.op == ttps_pkg::OP_NONE);
      load_clear = (state_ff == ttps_pkg::B_SWEEP) && sweep_last && sweep_rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = slot_ff;
      wr_data    = '0;
      unique case (state_ff)
         ttps_pkg::B_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ptr_ff;
         end
         ttps_pkg::B_LOOK: begin
            wr_en         = cmd_ff.op == ttps_pkg::OP_STORE;
            wr_data.key   = cmd_ff.key;
            wr_data.move  = cmd_ff.move;
            wr_data.score = cmd_ff.score;
            wr_data.eval  = cmd_ff.eval;
            wr_data.depth = cmd_ff.depth;
            wr_data.flags = cmd_ff.flags;
         end
         ttps_pkg::B_IDLE: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[q_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ttps_pkg::B_SWEEP;
         sweep_ptr_ff  <= '0;
         sweep_rsp_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hits_ff       <= '0;
         new_writes_ff <= '0;
         overwrites_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ttps_pkg::B_SWEEP) begin
            sweep_ptr_ff <= sweep_last ? '0 : sweep_ptr_ff + IDX_W'(1);
            if (sweep_last) begin
               sweep_rsp_ff <= 1'b0;
            end
         end
         if (q_pop && q_cmd.op == ttps_pkg::OP_CLEAR) begin
            sweep_rsp_ff  <= 1'b1;
            new_writes_ff <= '0;
         end
         if (load_look || load_nop || load_clear) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load_look && look_hit) begin
            hits_ff <= hits_ff + ttps_pkg::COUNT_W'(1);
         end
         if (load_look && cmd_ff.op == ttps_pkg::OP_STORE) begin
            if (rd_ff.key == '0) begin
               new_writes_ff <= new_writes_ff + ttps_pkg::COUNT_W'(1);
            end else begin
               overwrites_ff <= overwrites_ff + ttps_pkg::COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff  <= q_cmd;
         slot_ff <= q_slot;
      end
      if (load_look && look_hit) begin
         hit_ff   <= 1'b1;
         move_ff  <= rd_ff.move;
         score_ff <= look_score;
         eval_ff  <= rd_ff.eval;
         depth_ff <= rd_ff.depth;
         flags_ff <= rd_ff.flags;
      end else if (load_look || load_nop || load_clear) begin
         hit_ff   <= 1'b0;
         move_ff  <= '0;
         score_ff <= '0;
         eval_ff  <= '0;
         depth_ff <= '0;
         flags_ff <= '0;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hit              = hit_ff;
   assign rsp_found_move       = move_ff;
   assign rsp_found_score      = score_ff;
   assign rsp_found_eval       = eval_ff;
   assign rsp_found_depth      = depth_ff;
   assign rsp_found_flags      = flags_ff;
   assign rsp_hits_total       = hits_ff;
   assign rsp_new_writes_total = new_writes_ff;
   assign rsp_overwrites_total = overwrites_ff;

endmodule

// ----- hw/rtl/transposition_table_probe_store_core.sv -----
`timescale 1ns / 1ps
// Direct-mapped transposition table of TABLE_ENTRIES slots, indexed by pos_key modulo
// TABLE_ENTRIES. The front stage takes a new request only once it has pushed the last one
// into the queue; when TABLE_ENTRIES is a power of two the slot is the low key bits,
// otherwise a remainder unit consumes 4 key bits per cycle for each probe or store (clear
// and unused requests skip it). A 2-entry queue feeds the back stage, which does one
// read-modify-write of the table memory (one read port, one write port) per probe or
// store and pops no new command until it is done. A clear sweeps the memory one slot a
// cycle, then returns its response; the same sweep runs after reset, and requests are
// stalled while a sweep is in progress. mate_threshold is written through the csr channel,
// which is always ready, and should only change while the block is idle.
module transposition_table_probe_store_core #(
   parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [ttps_pkg::KEY_W-1:0]           req_pos_key,
   input  logic [ttps_pkg::PLY_W-1:0]           req_ply,
   input  logic [ttps_pkg::MOVE_W-1:0]          req_move,
   input  logic signed [ttps_pkg::SCORE_W-1:0]  req_score,
   input  logic signed [ttps_pkg::SCORE_W-1:0]  req_eval,
   input  logic [ttps_pkg::DEPTH_W-1:0]         req_depth,
   input  logic [ttps_pkg::FLAGS_W-1:0]         req_flags,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_hit,
   output logic [ttps_pkg::MOVE_W-1:0]          rsp_found_move,
   output logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_score,
   output logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_eval,
   output logic [ttps_pkg::DEPTH_W-1:0]         rsp_found_depth,
   output logic [ttps_pkg::FLAGS_W-1:0]         rsp_found_flags,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_hits_total,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_new_writes_total,
   output logic [ttps_pkg::COUNT_W-1:0]         rsp_overwrites_total,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttps_pkg::THR_W-1:0]           csr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CMD_W = $bits(ttps_pkg::cmd_type);
   localparam int Q_W   = IDX_W + CMD_W;

   logic [ttps_pkg::THR_W-1:0] mate_threshold_ff;
   logic                       table_busy;
   logic                       q_push, q_full, q_pop, q_empty;
   logic [IDX_W-1:0]           push_slot;
   ttps_pkg::cmd_type          push_cmd;
   logic [Q_W-1:0]             pop_data;
   logic [IDX_W-1:0]           pop_slot;
   ttps_pkg::cmd_type          pop_cmd;

   assign csr_ready = 1'b1;
   assign pop_slot  = pop_data[Q_W-1:CMD_W];
   assign pop_cmd   = pop_data[CMD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mate_threshold_ff <= ttps_pkg::MATE_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         mate_threshold_ff <= csr_data;
      end
   end

   ttps_front #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pos_key    (req_pos_key),
      .req_ply        (req_ply),
      .req_move       (req_move),
      .req_score      (req_score),
      .req_eval       (req_eval),
      .req_depth      (req_depth),
      .req_flags      (req_flags),
      .mate_threshold (mate_threshold_ff),
      .table_busy     (table_busy),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_slot         (push_slot),
      .q_cmd          (push_cmd)
   );

   ttps_queue #(
      .DATA_W (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_slot, push_cmd}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   ttps_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .IDX_W         (IDX_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .q_slot               (pop_slot),
      .q_cmd                (pop_cmd),
      .mate_threshold       (mate_threshold_ff),
      .table_busy           (table_busy),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_found_move       (rsp_found_move),
      .rsp_found_score      (rsp_found_score),
      .rsp_found_eval       (rsp_found_eval),
      .rsp_found_depth      (rsp_found_depth),
      .rsp_found_flags      (rsp_found_flags),
      .rsp_hits_total       (rsp_hits_total),
      .rsp_new_writes_total (rsp_new_writes_total),
      .rsp_overwrites_total (rsp_overwrites_total)
   );

endmodule

// ----- hw/rtl/ttps_checker.sv -----
`timescale 1ns / 1ps
module ttps_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_hit,
   input logic [ttps_pkg::MOVE_W-1:0]          rsp_found_move,
   input logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_score,
   input logic signed [ttps_pkg::SCORE_W-1:0]  rsp_found_eval,
   input logic [ttps_pkg::DEPTH_W-1:0]         rsp_found_depth,
   input logic [ttps_pkg::FLAGS_W-1:0]         rsp_found_flags,
   input logic [ttps_pkg::COUNT_W-1:0]         rsp_hits_total,
   input logic [ttps_pkg::COUNT_W-1:0]         rsp_overwrites_total
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_found_move)
         && $stable(rsp_found_score))
      else $error("response transaction changed while stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_found_move == '0 && rsp_found_score == '0
         && rsp_found_eval == '0 && rsp_found_depth == '0 && rsp_found_flags == '0)
      else $error("miss response carries nonzero contents");

   a_hits_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_hits_total == $past(rsp_hits_total)
         || rsp_hits_total == $past(rsp_hits_total) + 32'd1)
      else $error("hit count jumped");

   a_overwrites_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_overwrites_total == $past(rsp_overwrites_total)
         || rsp_overwrites_total == $past(rsp_overwrites_total) + 32'd1)
      else $error("overwrite count jumped");

endmodule

bind transposition_table_probe_store_core ttps_checker u_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
   import ttps_pkg::*;

   localparam int TABLE_N     = TABLE_ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 485;
   localparam int HOLD_CYCLES = 300;
   localparam int POOL_N      = 48;
   localparam logic [KEY_W-1:0] KEY_ONES = '1;

   typedef struct packed {
      logic               hit;
      logic [MOVE_W-1:0]  move;
      logic [SCORE_W-1:0] score;
      logic [SCORE_W-1:0] eval;
      logic [DEPTH_W-1:0] depth;
      logic [FLAGS_W-1:0] flags;
      logic [COUNT_W-1:0] hits;
      logic [COUNT_W-1:0] new_writes;
      logic [COUNT_W-1:0] overwrites;
   } probe_result_t;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_EVERY_THIRD,
      RX_HEAVY
   } rx_style_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   cmd_type drv_cmd = '0;
   logic [1:0] req_type;
   logic [KEY_W-1:0] req_pos_key;
   logic [PLY_W-1:0] req_ply;
   logic [MOVE_W-1:0] req_move;
   logic signed [SCORE_W-1:0] req_score;
   logic signed [SCORE_W-1:0] req_eval;
   logic [DEPTH_W-1:0] req_depth;
   logic [FLAGS_W-1:0] req_flags;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [MOVE_W-1:0] rsp_found_move;
   logic signed [SCORE_W-1:0] rsp_found_score;
   logic signed [SCORE_W-1:0] rsp_found_eval;
   logic [DEPTH_W-1:0] rsp_found_depth;
   logic [FLAGS_W-1:0] rsp_found_flags;
   logic [COUNT_W-1:0] rsp_hits_total;
   logic [COUNT_W-1:0] rsp_new_writes_total;
   logic [COUNT_W-1:0] rsp_overwrites_total;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [THR_W-1:0] csr_data = MATE_THRESHOLD_RESET;

   assign req_type    = drv_cmd.op;
   assign req_pos_key = drv_cmd.key;
   assign req_ply     = drv_cmd.ply;
   assign req_move    = drv_cmd.move;
   assign req_score   = drv_cmd.score;
   assign req_eval    = drv_cmd.eval;
   assign req_depth   = drv_cmd.depth;
   assign req_flags   = drv_cmd.flags;

   transposition_table_probe_store_core #(
      .TABLE_ENTRIES(TABLE_N)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_pos_key          (req_pos_key),
      .req_ply              (req_ply),
      .req_move             (req_move),
      .req_score            (req_score),
      .req_eval             (req_eval),
      .req_depth            (req_depth),
      .req_flags            (req_flags),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hit              (rsp_hit),
      .rsp_found_move       (rsp_found_move),
      .rsp_found_score      (rsp_found_score),
      .rsp_found_eval       (rsp_found_eval),
      .rsp_found_depth      (rsp_found_depth),
      .rsp_found_flags      (rsp_found_flags),
      .rsp_hits_total       (rsp_hits_total),
      .rsp_new_writes_total (rsp_new_writes_total),
      .rsp_overwrites_total (rsp_overwrites_total),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   // shadow copy of the table, counters and threshold
   logic [KEY_W-1:0]   tt_key   [TABLE_N];
   logic [MOVE_W-1:0]  tt_move  [TABLE_N];
   logic [SCORE_W-1:0] tt_score [TABLE_N];
   logic [SCORE_W-1:0] tt_eval  [TABLE_N];
   logic [DEPTH_W-1:0] tt_depth [TABLE_N];
   logic [FLAGS_W-1:0] tt_flags [TABLE_N];
   logic [COUNT_W-1:0] hit_count;
   logic [COUNT_W-1:0] new_write_count;
   logic [COUNT_W-1:0] overwrite_count;
   logic [THR_W-1:0]   mate_thr;

   cmd_type       pending_q[$];
   probe_result_t expected_q[$];
   logic [KEY_W-1:0] key_pool [POOL_N];

   int errors = 0;
   int rsp_seen = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   logic req_fire = 1'b0;
   int hold_left = 0;
   int holds_done = 0;
   int mode_left = 0;
   int third_ctr = 0;
   rx_style_t rx_style = RX_OPEN;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void wipe_table();
      for (int j = 0; j < TABLE_N; j++) begin
         tt_key[j]   = '0;
         tt_move[j]  = '0;
         tt_score[j] = '0;
         tt_eval[j]  = '0;
         tt_depth[j] = '0;
         tt_flags[j] = '0;
      end
      new_write_count = '0;
   endfunction

   function automatic logic [SCORE_W-1:0] mate_shift(input logic signed [SCORE_W-1:0] s,
                                                    input logic [PLY_W-1:0] ply,
                                                    input bit outward);
      int v;
      int t;
      int p;
      v = s;
      t = mate_thr;
      p = ply;
      if (v > t) begin
         v = outward ? v + p : v - p;
      end else if (v < -t) begin
         v = outward ? v - p : v + p;
      end
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return v[15:0];
   endfunction

   function automatic probe_result_t predict_access(input cmd_type c);
      probe_result_t res;
      int unsigned slot;
      res = '0;
      slot = c.key % TABLE_N;
      case (c.op)
         OP_PROBE: begin
            if (tt_key[slot] == c.key) begin
               hit_count++;
               res.hit   = 1'b1;
               res.move  = tt_move[slot];
               res.score = mate_shift(tt_score[slot], c.ply, 1'b0);
               res.eval  = tt_eval[slot];
               res.depth = tt_depth[slot];
               res.flags = tt_flags[slot];
            end
         end
         OP_STORE: begin
            if (tt_key[slot] == '0) begin
               new_write_count++;
            end else begin
               overwrite_count++;
            end
            tt_key[slot]   = c.key;
            tt_move[slot]  = c.move;
            tt_score[slot] = mate_shift(c.score, c.ply, 1'b1);
            tt_eval[slot]  = c.eval;
            tt_depth[slot] = c.depth;
            tt_flags[slot] = c.flags;
         end
         OP_CLEAR: wipe_table();
         default: ;
      endcase
      res.hits       = hit_count;
      res.new_writes = new_write_count;
      res.overwrites = overwrite_count;
      return res;
   endfunction

   function automatic void queue_cmd(input op_type op, input logic [KEY_W-1:0] key,
                                     input logic [PLY_W-1:0] ply, input logic [MOVE_W-1:0] move,
                                     input logic [SCORE_W-1:0] score,
                                     input logic [SCORE_W-1:0] eval,
                                     input logic [DEPTH_W-1:0] depth,
                                     input logic [FLAGS_W-1:0] flags);
      cmd_type c;
      c.op    = op;
      c.key   = key;
      c.ply   = ply;
      c.move  = move;
      c.score = score;
      c.eval  = eval;
      c.depth = depth;
      c.flags = flags;
      pending_q.push_back(c);
   endfunction

   function automatic void queue_probe(input logic [KEY_W-1:0] key, input logic [PLY_W-1:0] ply);
      queue_cmd(OP_PROBE, key, ply, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 63), $urandom_range(0, 3));
   endfunction

   function automatic logic [SCORE_W-1:0] pick_score();
      int v;
      case ($urandom_range(0, 7))
         0: v = mate_thr + $urandom_range(0, 3);
         1: v = -(mate_thr + $urandom_range(0, 3));
         2: v = 32767 - $urandom_range(0, 130);
         3: v = -32768 + $urandom_range(0, 130);
         default: v = $urandom_range(0, 65535) - 32768;
      endcase
      if (v > 32767) begin
         v = 32767;
      end else if (v < -32768) begin
         v = -32768;
      end
      return v[15:0];
   endfunction

   function automatic cmd_type random_cmd();
      cmd_type c;
      int pick;
      c.key   = key_pool[$urandom_range(0, POOL_N - 1)];
      c.ply   = $urandom_range(0, 127);
      c.move  = $urandom;
      c.score = pick_score();
      c.eval  = $urandom_range(0, 65535);
      c.depth = $urandom_range(0, 63);
      c.flags = $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         c.op = OP_STORE;
      end else if (pick < 86) begin
         c.op = OP_PROBE;
      end else if (pick < 92) begin
         c.op  = OP_PROBE;
         c.key = {$urandom, $urandom};
      end else if (pick < 94) begin
         c.op  = OP_STORE;
         c.key = {$urandom, $urandom};
      end else if (pick < 99) begin
         c.op = OP_NONE;
      end else begin
         c.op = OP_CLEAR;
      end
      return c;
   endfunction

   task automatic write_threshold(input logic [THR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      mate_thr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %h actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   // request side: capture the transaction at the edge, present the next one at the falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_q.push_back(predict_access(drv_cmd));
         req_fire <= 1'b1;
      end else begin
         req_fire <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            drv_cmd   <= pending_q.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: hold off twice for a long stretch, otherwise stall by the current style
   always @(negedge clock) begin
      if ((holds_done == 0 && rsp_seen >= 150) || (holds_done == 1 && rsp_seen >= 1200)) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            rx_style  = rx_style_t'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         third_ctr++;
         case (rx_style)
            RX_OPEN:        rsp_stall <= 1'b0;
            RX_COIN:        rsp_stall <= $urandom_range(0, 1);
            RX_EVERY_THIRD: rsp_stall <= (third_ctr % 3 == 0);
            default:        rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin : response_check
      probe_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_q.size() == 0) begin
            $display("%0t ns: response with nothing outstanding, expected none actual hit %b",
                     $time, rsp_hit);
            errors++;
         end else begin
            want = expected_q.pop_front();
            check_field("hit", want.hit, rsp_hit);
            check_field("found_move", want.move, rsp_found_move);
            check_field("found_score", want.score, $unsigned(rsp_found_score));
            check_field("found_eval", want.eval, $unsigned(rsp_found_eval));
            check_field("found_depth", want.depth, rsp_found_depth);
            check_field("found_flags", want.flags, rsp_found_flags);
            check_field("hits_total", want.hits, rsp_hits_total);
            check_field("new_writes_total", want.new_writes, rsp_new_writes_total);
            check_field("overwrites_total", want.overwrites, rsp_overwrites_total);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [THR_W-1:0] thr_plan [4];
      int pool_slot [16];
      int i;
      int n;
      wipe_table();
      hit_count       = '0;
      overwrite_count = '0;
      mate_thr        = MATE_THRESHOLD_RESET;

      pool_slot[0] = 0;
      pool_slot[1] = TABLE_N - 1;
      for (i = 2; i < 16; i++) begin
         pool_slot[i] = $urandom_range(0, TABLE_N - 1);
      end
      for (i = 0; i < POOL_N; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i] = key_pool[i] - (key_pool[i] % TABLE_N) + pool_slot[i % 16];
      end
      key_pool[0] = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_probe(64'h0000_0000_0000_0123, 7'd0);
      queue_probe(64'd0, 7'd127);
      queue_cmd(OP_STORE, KEY_ONES, 7'd127, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 6'd63, 2'd3);
      queue_probe(KEY_ONES, 7'd127);
      queue_probe(KEY_ONES, 7'd0);
      queue_cmd(OP_STORE, 64'h8000_0000_0000_0001, 7'd127, 32'd0, 16'h8000, 16'h7FFF, 6'd0, 2'd0);
      queue_probe(64'h8000_0000_0000_0001, 7'd127);
      queue_cmd(OP_STORE, 64'h0000_0000_0000_03FF, 7'd100, 32'h1357_9BDF, 16'sd29936, 16'sd0,
                6'd17, 2'd1);
      queue_probe(KEY_ONES, 7'd1);
      queue_probe(64'h0000_0000_0000_03FF, 7'd100);
      queue_cmd(OP_STORE, 64'h0000_1234_0000_0005, 7'd5, 32'h0000_0001, 16'sd29937, -16'sd5,
                6'd40, 2'd2);
      queue_probe(64'h0000_1234_0000_0005, 7'd5);
      queue_cmd(OP_STORE, 64'hDEAD_0000_0000_0407, 7'd3, 32'h8000_0000, -16'sd29937, 16'sd1234,
                6'd1, 2'd3);
      queue_probe(64'hDEAD_0000_0000_0407, 7'd64);
      queue_cmd(OP_STORE, 64'd0, 7'd9, 32'hA5A5_5A5A, 16'sd100, 16'sd7, 6'd5, 2'd1);
      queue_cmd(OP_STORE, 64'd0, 7'd9, 32'h0F0F_F0F0, -16'sd100, -16'sd7, 6'd6, 2'd2);
      queue_probe(64'd0, 7'd0);
      queue_cmd(OP_NONE, KEY_ONES, 7'd127, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 6'd63, 2'd3);
      queue_cmd(OP_CLEAR, 64'h0000_1234_0000_0005, 7'd5, 32'd1, 16'sd1, 16'sd1, 6'd1, 2'd1);
      queue_probe(64'h0000_1234_0000_0005, 7'd5);
      queue_probe(64'd0, 7'd0);
      queue_cmd(OP_STORE, KEY_ONES, 7'd0, 32'h7FFF_FFFF, -16'sd32767, 16'sd0, 6'd31, 2'd0);
      queue_probe(KEY_ONES, 7'd0);
      queue_cmd(OP_NONE, 64'd0, 7'd0, 32'd0, 16'sd0, 16'sd0, 6'd0, 2'd0);

      thr_plan[0] = '0;
      thr_plan[1] = '1;
      thr_plan[2] = $urandom_range(1, 32766);
      thr_plan[3] = MATE_THRESHOLD_RESET;
      for (n = 0; n < 4; n++) begin
         wait_drained();
         write_threshold(thr_plan[n]);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            pending_q.push_back(random_cmd());
         end
      end

      wait_drained();
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
